/* src/i2cram_pkg.sv */
// shared types and constants of the i2c register access master
package i2cram_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [6:0] DEV_ADDR_RESET = 7'd104;
   localparam logic [2:0] LAST_BIT       = 3'd7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_DEV_ADDR = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_WRITE,
      OP_READ,
      OP_NONE
   } op_type;

   typedef enum logic [14:0] {
      PH_IDLE    = 15'b000000000000001,
      PH_START_A = 15'b000000000000010,
      PH_ADDR_W  = 15'b000000000000100,
      PH_ACK_A   = 15'b000000000001000,
      PH_REG     = 15'b000000000010000,
      PH_ACK_R   = 15'b000000000100000,
      PH_DATA    = 15'b000000001000000,
      PH_ACK_D   = 15'b000000010000000,
      PH_START_B = 15'b000000100000000,
      PH_ADDR_R  = 15'b000001000000000,
      PH_ACK_B   = 15'b000010000000000,
      PH_RX_PREP = 15'b000100000000000,
      PH_RX_BITS = 15'b001000000000000,
      PH_TX_NACK = 15'b010000000000000,
      PH_STOP    = 15'b100000000000000
   } phase_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } entry_type;

   // handoff between front queue and back sequencer
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

/* src/i2cram_if.sv */
// request and response channel interfaces
interface i2cram_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, kind, reg_addr, write_data, sda_in, input ready);
   modport sink (input valid, kind, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cram_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       nack_seen;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                   nack_seen, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                 nack_seen, output ready);
endinterface

/* src/i2cram_front.sv */
// front end: accepts request beats, classifies them and queues them
module i2cram_front #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   i2cram_req_if.sink                 req_chan,
   input  logic                       pop,
   output i2cram_pkg::queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   i2cram_pkg::entry_type entry_ff [DEPTH];
   i2cram_pkg::entry_type entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic accept;

   assign req_chan.ready = (count_ff != CNT_FULL);
   assign accept = req_chan.valid && req_chan.ready;

   // classify the kind code
   always_comb begin
      entry_in.reg_addr   = req_chan.reg_addr;
      entry_in.write_data = req_chan.write_data;
      entry_in.sda_in     = req_chan.sda_in;
      case (req_chan.kind)
         i2cram_pkg::KIND_TICK:  entry_in.op = i2cram_pkg::OP_TICK;
         i2cram_pkg::KIND_WRITE: entry_in.op = i2cram_pkg::OP_WRITE;
         i2cram_pkg::KIND_READ:  entry_in.op = i2cram_pkg::OP_READ;
         default:                entry_in.op = i2cram_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!accept && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

endmodule

/* src/i2cram_seq.sv */
// back end: pin sequencer and registered response stage
module i2cram_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  i2cram_pkg::queue_head_type head,
   output logic                       pop,
   input  logic [6:0]                 dev_addr,
   i2cram_rsp_if.source               rsp_chan
);

   i2cram_pkg::phase_type phase_ff, phase_in;
   logic [1:0] step_ff, step_in;
   logic [2:0] bit_ff, bit_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] shift_ff, shift_in;
   logic       nack_ff, nack_in;
   logic       scl_line_ff, scl_line_in;
   logic       sda_line_ff, sda_line_in;
   logic       done;

   logic       rsp_valid_ff;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_nack_ff;
   logic [7:0] rsp_byte_ff;

   logic [7:0]            tx_byte;
   logic                  tx_bit;
   i2cram_pkg::phase_type next_phase;

   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);

   // byte on the wire for the current send phase
   always_comb begin
      case (phase_ff)
         i2cram_pkg::PH_ADDR_W: tx_byte = {dev_addr, 1'b0};
         i2cram_pkg::PH_ADDR_R: tx_byte = {dev_addr, 1'b1};
         i2cram_pkg::PH_REG:    tx_byte = reg_ff;
         default:               tx_byte = data_ff;
      endcase
   end

   assign tx_bit = tx_byte[i2cram_pkg::LAST_BIT - bit_ff];

   // phase that follows a start, send or ack phase
   always_comb begin
      case (phase_ff)
         i2cram_pkg::PH_START_A: next_phase = i2cram_pkg::PH_ADDR_W;
         i2cram_pkg::PH_ADDR_W:  next_phase = i2cram_pkg::PH_ACK_A;
         i2cram_pkg::PH_ACK_A:   next_phase = i2cram_pkg::PH_REG;
         i2cram_pkg::PH_REG:     next_phase = i2cram_pkg::PH_ACK_R;
         i2cram_pkg::PH_ACK_R:
            next_phase = is_read_ff ? i2cram_pkg::PH_START_B : i2cram_pkg::PH_DATA;
         i2cram_pkg::PH_DATA:    next_phase = i2cram_pkg::PH_ACK_D;
         i2cram_pkg::PH_ACK_D:   next_phase = i2cram_pkg::PH_STOP;
         i2cram_pkg::PH_START_B: next_phase = i2cram_pkg::PH_ADDR_R;
         i2cram_pkg::PH_ADDR_R:  next_phase = i2cram_pkg::PH_ACK_B;
         i2cram_pkg::PH_ACK_B:   next_phase = i2cram_pkg::PH_RX_PREP;
         default:                next_phase = i2cram_pkg::PH_IDLE;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      is_read_in  = is_read_ff;
      reg_in      = reg_ff;
      data_in     = data_ff;
      shift_in    = shift_ff;
      nack_in     = nack_ff;
      scl_line_in = scl_line_ff;
      sda_line_in = sda_line_ff;
      done        = 1'b0;
      if (pop) begin
         case (head.entry.op)
            i2cram_pkg::OP_TICK: begin
               case (phase_ff)
                  i2cram_pkg::PH_IDLE: begin
                  end
                  i2cram_pkg::PH_START_A, i2cram_pkg::PH_START_B: begin
                     step_in = step_ff + 2'd1;
                     case (step_ff)
                        2'd0: sda_line_in = 1'b1;
                        2'd1: scl_line_in = 1'b1;
                        2'd2: sda_line_in = 1'b0;
                        default: begin
                           scl_line_in = 1'b0;
                           phase_in    = next_phase;
                           step_in     = 2'd0;
                           bit_in      = 3'd0;
                        end
                     endcase
                  end
                  i2cram_pkg::PH_ADDR_W, i2cram_pkg::PH_REG, i2cram_pkg::PH_DATA,
                  i2cram_pkg::PH_ADDR_R: begin
                     if (step_ff == 2'd0) begin
                        sda_line_in = tx_bit;
                        step_in     = 2'd1;
                     end else if (step_ff == 2'd1) begin
                        scl_line_in = 1'b1;
                        step_in     = 2'd2;
                     end else begin
                        scl_line_in = 1'b0;
                        step_in     = 2'd0;
                        if (bit_ff == i2cram_pkg::LAST_BIT) begin
                           phase_in = next_phase;
                           bit_in   = 3'd0;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end
                  end
                  i2cram_pkg::PH_ACK_A, i2cram_pkg::PH_ACK_R, i2cram_pkg::PH_ACK_D,
                  i2cram_pkg::PH_ACK_B: begin
                     step_in = step_ff + 2'd1;
                     case (step_ff)
                        2'd0: sda_line_in = 1'b1;
                        2'd1: scl_line_in = 1'b1;
                        2'd2: begin
                           if (head.entry.sda_in) begin
                              nack_in = 1'b1;
                           end
                        end
                        default: begin
                           scl_line_in = 1'b0;
                           phase_in    = next_phase;
                           step_in     = 2'd0;
                           bit_in      = 3'd0;
                        end
                     endcase
                  end
                  i2cram_pkg::PH_RX_PREP: begin
                     sda_line_in = 1'b1;
                     shift_in    = 8'd0;
                     phase_in    = i2cram_pkg::PH_RX_BITS;
                     step_in     = 2'd0;
                     bit_in      = 3'd0;
                  end
                  i2cram_pkg::PH_RX_BITS: begin
                     if (step_ff == 2'd0) begin
                        scl_line_in = 1'b1;
                        step_in     = 2'd1;
                     end else if (step_ff == 2'd1) begin
                        shift_in = {shift_ff[6:0], head.entry.sda_in};
                        step_in  = 2'd2;
                     end else begin
                        scl_line_in = 1'b0;
                        step_in     = 2'd0;
                        if (bit_ff == i2cram_pkg::LAST_BIT) begin
                           phase_in = i2cram_pkg::PH_TX_NACK;
                           bit_in   = 3'd0;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end
                  end
                  i2cram_pkg::PH_TX_NACK: begin
                     if (step_ff == 2'd0) begin
                        sda_line_in = 1'b1;
                        step_in     = 2'd1;
                     end else if (step_ff == 2'd1) begin
                        scl_line_in = 1'b1;
                        step_in     = 2'd2;
                     end else begin
                        scl_line_in = 1'b0;
                        phase_in    = i2cram_pkg::PH_STOP;
                        step_in     = 2'd0;
                        bit_in      = 3'd0;
                     end
                  end
                  i2cram_pkg::PH_STOP: begin
                     if (step_ff == 2'd0) begin
                        sda_line_in = 1'b0;
                        step_in     = 2'd1;
                     end else if (step_ff == 2'd1) begin
                        scl_line_in = 1'b1;
                        step_in     = 2'd2;
                     end else begin
                        sda_line_in = 1'b1;
                        phase_in    = i2cram_pkg::PH_IDLE;
                        step_in     = 2'd0;
                        bit_in      = 3'd0;
                        done        = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = i2cram_pkg::PH_IDLE;
                     step_in  = 2'd0;
                     bit_in   = 3'd0;
                  end
               endcase
            end
            i2cram_pkg::OP_WRITE, i2cram_pkg::OP_READ: begin
               if (phase_ff == i2cram_pkg::PH_IDLE) begin
                  is_read_in = (head.entry.op == i2cram_pkg::OP_READ);
                  reg_in     = head.entry.reg_addr;
                  data_in    = head.entry.write_data;
                  nack_in    = 1'b0;
                  phase_in   = i2cram_pkg::PH_START_A;
                  step_in    = 2'd0;
                  bit_in     = 3'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cram_pkg::PH_IDLE;
         step_ff      <= 2'd0;
         bit_ff       <= 3'd0;
         is_read_ff   <= 1'b0;
         reg_ff       <= 8'd0;
         data_ff      <= 8'd0;
         shift_ff     <= 8'd0;
         nack_ff      <= 1'b0;
         scl_line_ff  <= 1'b1;
         sda_line_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         bit_ff      <= bit_in;
         is_read_ff  <= is_read_in;
         reg_ff      <= reg_in;
         data_ff     <= data_in;
         shift_ff    <= shift_in;
         nack_ff     <= nack_in;
         scl_line_ff <= scl_line_in;
         sda_line_ff <= sda_line_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_ff  <= scl_line_in;
         rsp_sda_ff  <= sda_line_in;
         rsp_busy_ff <= (phase_in != i2cram_pkg::PH_IDLE);
         rsp_done_ff <= done;
         rsp_byte_ff <= (done && is_read_ff) ? shift_in : 8'd0;
         rsp_nack_ff <= nack_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = rsp_scl_ff;
   assign rsp_chan.sda_level = rsp_sda_ff;
   assign rsp_chan.busy_res  = rsp_busy_ff;
   assign rsp_chan.done_res  = rsp_done_ff;
   assign rsp_chan.read_byte = rsp_byte_ff;
   assign rsp_chan.nack_seen = rsp_nack_ff;

endmodule

/* src/i2c_register_access_master.sv */
// top level of the bit-banged i2c register access master
// usage:
//   req_chan carries one beat per item: a tick (advances one pin operation),
//   a write request or a read request, with register number, write byte and
//   the sampled data line level
//   rsp_chan returns exactly one beat per request beat, in order: clock and
//   data line levels, busy, done, the read byte and the sticky nack flag
//   the csr port holds the seven-bit device address (byte address 0)
// timing:
//   an accepted request beat waits in the front queue until it is popped, which
//   needs the response register free or being taken; on the pop the sequencer
//   steps and loads the response register, which then offers its response beat
//   throughput is one beat per clock while rsp_chan takes every beat; the
//   sequencer steps on every pop, so ticks may arrive back to back
// reset:
//   lines released high, sequencer idle, queue empty, device address 104
// stalls:
//   when rsp_chan is held off the response register keeps its beat, the
//   queue of QUEUE_DEPTH entries fills and then req_chan ready drops
module i2c_register_access_master #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   i2cram_req_if.sink                          req_chan,
   i2cram_rsp_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2cram_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [i2cram_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [i2cram_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   i2cram_pkg::queue_head_type head;
   logic       pop;
   logic [6:0] dev_addr_ff;
   logic       csr_hit;

   // register index is the word address
   assign csr_hit    = (csr_paddr[2] == i2cram_pkg::CSR_IDX_DEV_ADDR);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cram_pkg::DEV_ADDR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         dev_addr_ff <= csr_pwdata[6:0];
      end
   end

   assign csr_prdata = csr_hit ? {(i2cram_pkg::CSR_DATA_W - 7)'(0), dev_addr_ff} : '0;

   // front: accept and classify beats into the queue
   i2cram_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   // back: pin sequencer with registered response
   i2cram_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .dev_addr (dev_addr_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

/* verif/testbench.sv */
// self-checking testbench for the bit-banged i2c register access master
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int PIPE_SLACK   = 6;
   localparam int ITEM_TARGET  = 1050;
   localparam logic [i2cram_pkg::CSR_ADDR_W-1:0] DEV_ADDR_OFFSET =
      {i2cram_pkg::CSR_IDX_DEV_ADDR, 2'b00};

   // one response beat as the pins and flags should look
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       nack;
   } pin_result_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [i2cram_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [i2cram_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [i2cram_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   i2cram_req_if req_chan ();
   i2cram_rsp_if rsp_chan ();

   i2c_register_access_master uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bus sequencer mirror, advanced once per accepted request beat
   i2cram_pkg::phase_type bus_phase;
   logic [1:0] phase_step;
   logic [2:0] bit_idx;
   logic       rd_mode;
   logic [7:0] reg_hold;
   logic [7:0] data_hold;
   logic [7:0] rx_shift;
   logic       nack_hold;
   logic       scl_drive;
   logic       sda_drive;
   logic [6:0] target_addr;

   pin_result_type pending_pins[$];   // expected response beats, oldest first
   int mismatch_count = 0;
   int sent_count = 0;            // request beats accepted
   int rsp_count = 0;
   int cycle_count = 0;
   int hold_off_left = 0;         // long receiver hold-off, counted down per cycle
   int rsp_gap = 0;
   bit steady_flow = 1'b0;        // no random gaps on either side while set

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic void reset_model();
      bus_phase   = i2cram_pkg::PH_IDLE;
      phase_step  = '0;
      bit_idx     = '0;
      rd_mode     = 1'b0;
      reg_hold    = '0;
      data_hold   = '0;
      rx_shift    = '0;
      nack_hold   = 1'b0;
      scl_drive   = 1'b1;
      sda_drive   = 1'b1;
      target_addr = i2cram_pkg::DEV_ADDR_RESET;
   endfunction

   // byte on the wire for the current send phase, address taken live
   function automatic logic [7:0] outgoing_byte();
      case (bus_phase)
         i2cram_pkg::PH_ADDR_W: return {target_addr, 1'b0};
         i2cram_pkg::PH_ADDR_R: return {target_addr, 1'b1};
         i2cram_pkg::PH_REG:    return reg_hold;
         default:               return data_hold;
      endcase
   endfunction

   function automatic void enter_phase(input i2cram_pkg::phase_type nxt);
      bus_phase  = nxt;
      phase_step = '0;
      bit_idx    = '0;
   endfunction

   // start or repeated start: sda high, scl high, sda low, scl low
   function automatic void start_pins(input i2cram_pkg::phase_type nxt);
      case (phase_step)
         2'd0: sda_drive = 1'b1;
         2'd1: scl_drive = 1'b1;
         2'd2: sda_drive = 1'b0;
         default: begin
            scl_drive = 1'b0;
            enter_phase(nxt);
            return;
         end
      endcase
      phase_step++;
   endfunction

   // one bit per three ticks: set data, raise clock, drop clock
   function automatic void send_pins(input i2cram_pkg::phase_type nxt);
      logic [7:0] byte_now;
      byte_now = outgoing_byte();
      if (phase_step == 2'd0) begin
         sda_drive  = byte_now[i2cram_pkg::LAST_BIT - bit_idx];
         phase_step = 2'd1;
      end else if (phase_step == 2'd1) begin
         scl_drive  = 1'b1;
         phase_step = 2'd2;
      end else begin
         scl_drive  = 1'b0;
         phase_step = 2'd0;
         if (bit_idx == i2cram_pkg::LAST_BIT) enter_phase(nxt);
         else bit_idx++;
      end
   endfunction

   // ack slot: release sda, raise clock, sample, drop clock
   function automatic void ack_pins(input i2cram_pkg::phase_type nxt, input logic sda_bit);
      case (phase_step)
         2'd0: sda_drive = 1'b1;
         2'd1: scl_drive = 1'b1;
         2'd2: if (sda_bit) nack_hold = 1'b1;
         default: begin
            scl_drive = 1'b0;
            enter_phase(nxt);
            return;
         end
      endcase
      phase_step++;
   endfunction

   // one pin operation; returns 1 when the stop condition completes
   function automatic logic advance_bus(input logic sda_bit);
      case (bus_phase)
         i2cram_pkg::PH_START_A: start_pins(i2cram_pkg::PH_ADDR_W);
         i2cram_pkg::PH_ADDR_W:  send_pins(i2cram_pkg::PH_ACK_A);
         i2cram_pkg::PH_ACK_A:   ack_pins(i2cram_pkg::PH_REG, sda_bit);
         i2cram_pkg::PH_REG:     send_pins(i2cram_pkg::PH_ACK_R);
         i2cram_pkg::PH_ACK_R:
            ack_pins(rd_mode ? i2cram_pkg::PH_START_B : i2cram_pkg::PH_DATA, sda_bit);
         i2cram_pkg::PH_DATA:    send_pins(i2cram_pkg::PH_ACK_D);
         i2cram_pkg::PH_ACK_D:   ack_pins(i2cram_pkg::PH_STOP, sda_bit);
         i2cram_pkg::PH_START_B: start_pins(i2cram_pkg::PH_ADDR_R);
         i2cram_pkg::PH_ADDR_R:  send_pins(i2cram_pkg::PH_ACK_B);
         i2cram_pkg::PH_ACK_B:   ack_pins(i2cram_pkg::PH_RX_PREP, sda_bit);
         i2cram_pkg::PH_RX_PREP: begin
            sda_drive = 1'b1;
            rx_shift  = '0;
            enter_phase(i2cram_pkg::PH_RX_BITS);
         end
         i2cram_pkg::PH_RX_BITS: begin
            if (phase_step == 2'd0) begin
               scl_drive  = 1'b1;
               phase_step = 2'd1;
            end else if (phase_step == 2'd1) begin
               rx_shift   = {rx_shift[6:0], sda_bit};
               phase_step = 2'd2;
            end else begin
               scl_drive  = 1'b0;
               phase_step = 2'd0;
               if (bit_idx == i2cram_pkg::LAST_BIT) enter_phase(i2cram_pkg::PH_TX_NACK);
               else bit_idx++;
            end
         end
         i2cram_pkg::PH_TX_NACK: begin
            if (phase_step == 2'd0) begin
               sda_drive  = 1'b1;
               phase_step = 2'd1;
            end else if (phase_step == 2'd1) begin
               scl_drive  = 1'b1;
               phase_step = 2'd2;
            end else begin
               scl_drive = 1'b0;
               enter_phase(i2cram_pkg::PH_STOP);
            end
         end
         i2cram_pkg::PH_STOP: begin
            if (phase_step == 2'd0) begin
               sda_drive  = 1'b0;
               phase_step = 2'd1;
            end else if (phase_step == 2'd1) begin
               scl_drive  = 1'b1;
               phase_step = 2'd2;
            end else begin
               sda_drive = 1'b1;
               enter_phase(i2cram_pkg::PH_IDLE);
               return 1'b1;
            end
         end
         i2cram_pkg::PH_IDLE: ;
         default: enter_phase(i2cram_pkg::PH_IDLE);
      endcase
      return 1'b0;
   endfunction

   function automatic pin_result_type predict_pins(input i2cram_pkg::op_type kind,
                                                   input logic [7:0] reg_num,
                                                   input logic [7:0] data_byte,
                                                   input logic sda_bit);
      pin_result_type res;
      logic finished;
      finished = 1'b0;
      if (kind == i2cram_pkg::OP_TICK) begin
         finished = advance_bus(sda_bit);
      end else if ((kind == i2cram_pkg::OP_WRITE || kind == i2cram_pkg::OP_READ) &&
                   bus_phase == i2cram_pkg::PH_IDLE) begin
         // requests while busy and the unused kind fall through untouched
         rd_mode   = (kind == i2cram_pkg::OP_READ);
         reg_hold  = reg_num;
         data_hold = data_byte;
         nack_hold = 1'b0;
         enter_phase(i2cram_pkg::PH_START_A);
      end
      res.scl  = scl_drive;
      res.sda  = sda_drive;
      res.busy = (bus_phase != i2cram_pkg::PH_IDLE);
      res.done = finished;
      res.rx   = (finished && rd_mode) ? rx_shift : 8'h00;
      res.nack = nack_hold;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   function automatic void log_failure(input string what);
      if (mismatch_count < 10) $display("mismatch: %s", what);
      mismatch_count++;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want)
         log_failure($sformatf("beat %0d %s expected %0h got %0h", rsp_count, field, want, got));
   endfunction

   // compare each response beat against the oldest expectation
   always @(posedge clock) begin
      pin_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         if (pending_pins.size() == 0) begin
            log_failure($sformatf("beat %0d arrived with nothing expected", rsp_count));
         end else begin
            want = pending_pins.pop_front();
            check_field("scl_level", 32'(want.scl), 32'(rsp_chan.scl_level));
            check_field("sda_level", 32'(want.sda), 32'(rsp_chan.sda_level));
            check_field("busy_res", 32'(want.busy), 32'(rsp_chan.busy_res));
            check_field("done_res", 32'(want.done), 32'(rsp_chan.done_res));
            check_field("read_byte", 32'(want.rx), 32'(rsp_chan.read_byte));
            check_field("nack_seen", 32'(want.nack), 32'(rsp_chan.nack_seen));
         end
         rsp_count++;
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: long hold-off first, then random stalls
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else if (rsp_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // offer one beat; valid stays up when the next beat follows at once
   task automatic send_beat(input i2cram_pkg::op_type kind, input logic [7:0] reg_num,
                            input logic [7:0] data_byte, input logic sda_bit);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= kind;
      req_chan.reg_addr   <= reg_num;
      req_chan.write_data <= data_byte;
      req_chan.sda_in     <= sda_bit;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      pending_pins.push_back(predict_pins(kind, reg_num, data_byte, sda_bit));
   endtask

   // drop valid and let every expected beat come back
   task automatic settle_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // apb write then read back of the device address, pipeline idle
   task automatic set_target(input logic [6:0] value);
      logic [i2cram_pkg::CSR_DATA_W-1:0] readback;
      settle_pipeline();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DEV_ADDR_OFFSET;
      csr_pwdata  <= i2cram_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      target_addr = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("device_address readback", i2cram_pkg::CSR_DATA_W'(target_addr), readback);
   endtask

   // data line level for the next tick, shaped by what the bus expects
   function automatic logic line_sample(input int nack_pct, input bit rx_random,
                                        input logic [7:0] rx_pattern);
      case (bus_phase)
         i2cram_pkg::PH_ACK_A, i2cram_pkg::PH_ACK_R, i2cram_pkg::PH_ACK_D,
         i2cram_pkg::PH_ACK_B:
            return (int'($urandom_range(0, 99)) < nack_pct);
         i2cram_pkg::PH_RX_BITS:
            return rx_random ? 1'($urandom_range(0, 1))
                             : rx_pattern[i2cram_pkg::LAST_BIT - bit_idx];
         default:
            return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // tick until the transfer stops; optional noise beats and a device
   // address change after split_at ticks
   task automatic run_bus(input int nack_pct, input int noise_pct, input bit rx_random,
                          input logic [7:0] rx_pattern, input int split_at);
      int ticks;
      ticks = 0;
      while (bus_phase != i2cram_pkg::PH_IDLE) begin
         if (split_at > 0 && ticks == split_at) begin
            set_target(7'($urandom));
         end
         if (int'($urandom_range(0, 99)) < noise_pct) begin
            send_beat(i2cram_pkg::op_type'(2'($urandom_range(1, 3))), 8'($urandom),
                      8'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            send_beat(i2cram_pkg::OP_TICK, 8'($urandom), 8'($urandom),
                      line_sample(nack_pct, rx_random, rx_pattern));
            ticks++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset value written back to the address register, then beats that change nothing
   task automatic test_idle_behavior();
      set_target(i2cram_pkg::DEV_ADDR_RESET);
      send_beat(i2cram_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
      send_beat(i2cram_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
      send_beat(i2cram_pkg::OP_NONE, 8'hFF, 8'hFF, 1'b1);
      send_beat(i2cram_pkg::OP_NONE, 8'h00, 8'h00, 1'b0);
   endtask

   // writes at both address extremes, all acks then all nacks
   task automatic test_write_extremes();
      set_target(7'h00);
      send_beat(i2cram_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0);
      run_bus(0, 0, 1'b1, 8'h00, 0);
      set_target(7'h7F);
      send_beat(i2cram_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b1);
      run_bus(100, 0, 1'b1, 8'h00, 0);
   endtask

   // reads with all-ones and all-zeros received bytes
   task automatic test_read_extremes();
      set_target(7'h7F);
      send_beat(i2cram_pkg::OP_READ, 8'h00, 8'hFF, 1'b0);
      run_bus(0, 0, 1'b0, 8'hFF, 0);
      set_target(7'h00);
      send_beat(i2cram_pkg::OP_READ, 8'hFF, 8'h00, 1'b1);
      run_bus(100, 0, 1'b0, 8'h00, 0);
   endtask

   // requests and the unused kind while a transfer runs must be dropped
   task automatic test_busy_requests();
      set_target(i2cram_pkg::DEV_ADDR_RESET);
      send_beat(i2cram_pkg::OP_WRITE, 8'h3C, 8'h96, 1'b0);
      send_beat(i2cram_pkg::OP_READ, 8'hC3, 8'h69, 1'b1);
      send_beat(i2cram_pkg::OP_WRITE, 8'hFF, 8'hFF, 1'b0);
      run_bus(10, 30, 1'b1, 8'h00, 0);
   endtask

   // address register rewritten partway through the address byte
   task automatic test_address_change();
      set_target(7'h55);
      send_beat(i2cram_pkg::OP_READ, 8'h12, 8'h34, 1'b0);
      run_bus(0, 0, 1'b1, 8'h00, 10);
      send_beat(i2cram_pkg::OP_WRITE, 8'h9A, 8'hBC, 1'b0);
      run_bus(0, 0, 1'b1, 8'h00, 9);
   endtask

   // receiver holds off while the sender keeps offering ticks back to back
   task automatic test_backpressure();
      steady_flow = 1'b1;
      send_beat(i2cram_pkg::OP_WRITE, 8'h77, 8'h88, 1'b0);
      hold_off_left = 150;
      run_bus(0, 0, 1'b1, 8'h00, 0);
      send_beat(i2cram_pkg::OP_READ, 8'hE1, 8'h1E, 1'b0);
      hold_off_left = 90;
      run_bus(5, 0, 1'b1, 8'h00, 0);
      steady_flow = 1'b0;
   endtask

   // mostly complete transfers with random content, plus noise between,
   // until the overall beat count is reached
   task automatic test_random_traffic();
      int nack_pct;
      int split_at;
      do begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: set_target(7'h00);
               1: set_target(7'h7F);
               2: set_target(i2cram_pkg::DEV_ADDR_RESET);
               default: set_target(7'($urandom));
            endcase
         end
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 2))
            send_beat(($urandom_range(0, 1) == 0) ? i2cram_pkg::OP_TICK : i2cram_pkg::OP_NONE,
                      8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0: nack_pct = 50;
            1: nack_pct = 10;
            default: nack_pct = 0;
         endcase
         split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
         send_beat(($urandom_range(0, 1) == 0) ? i2cram_pkg::OP_WRITE : i2cram_pkg::OP_READ,
                   8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
         run_bus(nack_pct, $urandom_range(0, 5), 1'b1, 8'h00, split_at);
      end while (sent_count < ITEM_TARGET);
      steady_flow = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // sequence of the run
   // ------------------------------------------------------------------

   initial begin
      int waited;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = i2cram_pkg::OP_TICK;
      req_chan.reg_addr   = '0;
      req_chan.write_data = '0;
      req_chan.sda_in     = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_behavior();
      test_write_extremes();
      test_read_extremes();
      test_busy_requests();
      test_address_change();
      test_backpressure();
      test_random_traffic();

      // drain with a bound, then let the pipeline settle
      @(negedge clock);
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_pins.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pins.size() != 0)
         log_failure($sformatf("%0d beats never arrived", pending_pins.size()));
      repeat (PIPE_SLACK) @(posedge clock);
      if (mismatch_count == 0)
         $display("i2c_register_access_master test passed");
      else
         $display("i2c_register_access_master test failed");
      $finish;
   end

   // watchdog on total run length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("i2c_register_access_master test failed");
      $finish;
   end

endmodule
